/* src/ttcb_pkg.sv */
// shared types and constants of the text terminal cell buffer
// request structs, controller states, datapath commands and status
// no dependencies
package ttcb_pkg;

  localparam int CHAR_W       = 8;
  localparam int CELL_INDEX_W = 13;
  localparam int CFG_W        = 7;
  localparam int CFG_IDX_W    = 1;
  localparam int WIDTH_CAP    = 80;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS = 1'b1;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST  = 7'd80;
  localparam logic [CFG_W-1:0] SCREEN_ROWS_RST = 7'd25;

  // stream bytes with a meaning of their own
  localparam logic [CHAR_W-1:0] CH_NUL      = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_ESC      = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_TWO      = 8'h32;
  localparam logic [CHAR_W-1:0] CH_H        = 8'h48;
  localparam logic [CHAR_W-1:0] CH_J        = 8'h4A;
  localparam logic [CHAR_W-1:0] CH_K        = 8'h4B;

  typedef struct packed {
    logic                    action;
    logic [CHAR_W-1:0]       data_byte;
    logic                    end_of_write;
    logic [CELL_INDEX_W-1:0] cell_index;
  } in_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0]       cell_char;
    logic [CELL_INDEX_W-1:0] cursor_position;
    logic                    discarding;
  } out_req_t;

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_SEEN,
    ESC_BRACKET,
    ESC_TWO
  } esc_phase_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_DISPATCH,
    ST_DIV_CR,
    ST_DIV_LF,
    ST_DIV_LINE,
    ST_CLEAR,
    ST_SCROLL_CHK,
    ST_SCROLL_RUN,
    ST_RESP
  } ctl_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLR_STEP,
    DP_SCREEN_SETUP,
    DP_LINE_SETUP,
    DP_SCR_SETUP,
    DP_SCR_STEP,
    DP_DIV_START,
    DP_CR,
    DP_LF,
    DP_BS,
    DP_PUT,
    DP_HOME,
    DP_READ,
    DP_RESP
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [CHAR_W-1:0] chr;
    logic              drop;
  } dp_cmd_t;

  typedef struct packed {
    in_req_t item;
    logic    div_busy;
    logic    sweep_last;
    logic    cur_ge_size;
  } dp_stat_t;

endpackage

/* src/ttcb_rem.sv */
// bit-serial restoring remainder unit, one dividend bit per cycle
// no package dependencies
module ttcb_rem #(
  parameter int DVD_W = 14,
  parameter int DSR_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             busy,
  output logic [DSR_W-1:0] rem
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DSR_W-1:0] rem_r, rem_nxt;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    cnt_nxt = cnt_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = CNT_W'(DVD_W);
      dvd_nxt = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      rem_nxt = (trial >= {1'b0, divisor}) ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = (cnt_r != '0);
  assign rem  = rem_r;

endmodule

/* src/ttcb_dpath.sv */
// datapath: cell store, cursor, geometry, sweep counter and result register
// uses ttcb_pkg and ttcb_rem
module ttcb_dpath #(
  parameter int MAX_COLS = 80,
  parameter int MAX_ROWS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ttcb_pkg::dp_cmd_t                cmd,
  output ttcb_pkg::dp_stat_t               stat,
  input  ttcb_pkg::in_req_t                in_req,
  output ttcb_pkg::out_req_t               out_req,
  input  logic                             cfg_we,
  input  logic [ttcb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ttcb_pkg::CFG_W-1:0]       cfg_data
);

  localparam int CELLS  = MAX_COLS * MAX_ROWS;
  localparam int WCAP   = (MAX_COLS < ttcb_pkg::WIDTH_CAP) ? MAX_COLS : ttcb_pkg::WIDTH_CAP;
  localparam int W_W    = ttcb_pkg::CFG_W;
  localparam int CUR_W  = $clog2(CELLS + WCAP + 1);
  localparam int FULL_W = (CUR_W > ttcb_pkg::CELL_INDEX_W) ? CUR_W : ttcb_pkg::CELL_INDEX_W;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int RC_W   = (ROW_W > W_W) ? ROW_W : W_W;
  localparam int PROD_W = W_W + RC_W;
  localparam int CHW    = ttcb_pkg::CHAR_W;

  localparam logic [W_W-1:0]    WCAP_V  = W_W'(WCAP);
  localparam logic [RC_W-1:0]   ROWS_V  = RC_W'(MAX_ROWS);
  localparam logic [FULL_W-1:0] CELLS_V = FULL_W'(CELLS);
  localparam logic [CUR_W-1:0]  LAST_V  = CUR_W'(CELLS - 1);

  logic [CHW-1:0] mem [CELLS];

  logic [W_W-1:0]    lw_r, lw_nxt, sr_r, sr_nxt;
  logic [W_W-1:0]    w_r, w_eff;
  logic [RC_W-1:0]   rows_eff, sr_ext;
  logic [PROD_W-1:0] prod;
  logic [CUR_W-1:0]  size_r, keep_r;
  logic [CUR_W-1:0]  cur_r, cur_nxt, cnt_r, cnt_nxt, end_r, end_nxt;
  logic [CUR_W-1:0]  cur_dec, rem_ext, w_ext, line_start;
  ttcb_pkg::in_req_t  item_r, item_nxt;
  ttcb_pkg::out_req_t out_r, out_nxt;
  logic              oob_r, oob_nxt;
  logic [CHW-1:0]    rdata_r, wdata;
  logic              we, re;
  logic [FULL_W-1:0] waddr_f, raddr_f;
  logic              rem_start, rem_busy;
  logic [W_W-1:0]    rem;

  // effective geometry: zero counts as one, large values saturate
  assign w_eff    = (lw_r == '0) ? W_W'(1) : ((lw_r > WCAP_V) ? WCAP_V : lw_r);
  assign sr_ext   = RC_W'(sr_r);
  assign rows_eff = (sr_ext == '0) ? RC_W'(1) : ((sr_ext > ROWS_V) ? ROWS_V : sr_ext);
  assign prod     = PROD_W'(w_eff) * PROD_W'(rows_eff);

  assign rem_start  = (cmd.op == ttcb_pkg::DP_DIV_START);
  assign rem_ext    = CUR_W'(rem);
  assign w_ext      = CUR_W'(w_r);
  assign cur_dec    = cur_r - CUR_W'(1);
  assign line_start = cur_r - rem_ext;

  ttcb_rem #(
    .DVD_W (CUR_W),
    .DSR_W (W_W)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (cur_r),
    .divisor  (w_r),
    .busy     (rem_busy),
    .rem      (rem)
  );

  always_comb begin
    lw_nxt = lw_r;
    sr_nxt = sr_r;
    if (cfg_we) begin
      case (cfg_index)
        ttcb_pkg::CFG_LINE_WIDTH:  lw_nxt = cfg_data;
        ttcb_pkg::CFG_SCREEN_ROWS: sr_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_nxt  = cur_r;
    cnt_nxt  = cnt_r;
    end_nxt  = end_r;
    item_nxt = item_r;
    oob_nxt  = oob_r;
    out_nxt  = out_r;
    we       = 1'b0;
    waddr_f  = '0;
    wdata    = '0;
    re       = 1'b0;
    raddr_f  = '0;
    case (cmd.op)
      ttcb_pkg::DP_LOAD: begin
        item_nxt = in_req;
      end
      ttcb_pkg::DP_CLR_STEP: begin
        we      = (FULL_W'(cnt_r) < CELLS_V);
        waddr_f = FULL_W'(cnt_r);
        cnt_nxt = cnt_r + CUR_W'(1);
      end
      ttcb_pkg::DP_SCREEN_SETUP: begin
        cnt_nxt = '0;
        end_nxt = size_r - CUR_W'(1);
      end
      ttcb_pkg::DP_LINE_SETUP: begin
        cnt_nxt = line_start;
        end_nxt = line_start + w_ext - CUR_W'(1);
      end
      ttcb_pkg::DP_SCR_SETUP: begin
        cnt_nxt = '0;
        end_nxt = size_r - CUR_W'(1);
        re      = 1'b1;
        raddr_f = FULL_W'(w_r);
      end
      ttcb_pkg::DP_SCR_STEP: begin
        // row below moves up, the last row is blanked
        we      = (FULL_W'(cnt_r) < CELLS_V);
        waddr_f = FULL_W'(cnt_r);
        wdata   = (cnt_r < keep_r) ? rdata_r : '0;
        re      = 1'b1;
        raddr_f = FULL_W'(cnt_r) + FULL_W'(w_r) + FULL_W'(1);
        cnt_nxt = cnt_r + CUR_W'(1);
        if (cnt_r == end_r) begin
          cur_nxt = keep_r;
        end
      end
      ttcb_pkg::DP_CR: begin
        cur_nxt = line_start;
      end
      ttcb_pkg::DP_LF: begin
        if (rem != '0) begin
          cur_nxt = cur_r + (w_ext - rem_ext);
        end
      end
      ttcb_pkg::DP_BS: begin
        if (cur_r != '0) begin
          cur_nxt = cur_dec;
          we      = (FULL_W'(cur_dec) < CELLS_V);
          waddr_f = FULL_W'(cur_dec);
        end
      end
      ttcb_pkg::DP_PUT: begin
        we      = (FULL_W'(cur_r) < CELLS_V);
        waddr_f = FULL_W'(cur_r);
        wdata   = cmd.chr;
        cur_nxt = cur_r + CUR_W'(1);
      end
      ttcb_pkg::DP_HOME: begin
        cur_nxt = '0;
      end
      ttcb_pkg::DP_READ: begin
        oob_nxt = !(FULL_W'(item_r.cell_index) < CELLS_V);
        re      = !oob_nxt;
        raddr_f = FULL_W'(item_r.cell_index);
      end
      ttcb_pkg::DP_RESP: begin
        out_nxt.cell_char       = (item_r.action && !oob_r) ? rdata_r : '0;
        out_nxt.cursor_position = ttcb_pkg::CELL_INDEX_W'(cur_r);
        out_nxt.discarding      = cmd.drop;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr_f[ADDR_W-1:0]] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr_f[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r  <= ttcb_pkg::LINE_WIDTH_RST;
      sr_r  <= ttcb_pkg::SCREEN_ROWS_RST;
      cur_r <= '0;
      cnt_r <= '0;
      end_r <= LAST_V;
    end else begin
      lw_r  <= lw_nxt;
      sr_r  <= sr_nxt;
      cur_r <= cur_nxt;
      cnt_r <= cnt_nxt;
      end_r <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r    <= w_eff;
    size_r <= CUR_W'(prod);
    keep_r <= size_r - w_ext;
    item_r <= item_nxt;
    oob_r  <= oob_nxt;
    out_r  <= out_nxt;
  end

  assign stat.item        = item_r;
  assign stat.div_busy    = rem_busy;
  assign stat.sweep_last  = (cnt_r == end_r);
  assign stat.cur_ge_size = (cur_r >= size_r);
  assign out_req          = out_r;

endmodule

/* src/ttcb_ctrl.sv */
// controller: escape decoding, replay of held bytes, sequencing of datapath commands
// uses ttcb_pkg
module ttcb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ttcb_pkg::dp_stat_t  stat,
  output ttcb_pkg::dp_cmd_t   cmd
);

  ttcb_pkg::ctl_state_t state_r, state_nxt;
  ttcb_pkg::esc_phase_t phase_r, phase_nxt;
  logic drop_r, drop_nxt;
  logic rep_lb_r, rep_lb_nxt;
  logic rep_two_r, rep_two_nxt;
  logic cur_pend_r, cur_pend_nxt;
  logic eow_pend_r, eow_pend_nxt;
  logic out_valid_r, out_valid_nxt;
  logic mismatch;
  logic start_plain;
  logic [ttcb_pkg::CHAR_W-1:0] plain_chr;
  logic [ttcb_pkg::CHAR_W-1:0] b;

  assign b = stat.item.data_byte;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    drop_nxt      = drop_r;
    rep_lb_nxt    = rep_lb_r;
    rep_two_nxt   = rep_two_r;
    cur_pend_nxt  = cur_pend_r;
    eow_pend_nxt  = eow_pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = ttcb_pkg::DP_NOP;
    cmd.chr       = '0;
    cmd.drop      = drop_r;
    in_ready      = 1'b0;
    mismatch      = 1'b0;
    start_plain   = 1'b0;
    plain_chr     = ttcb_pkg::CH_NUL;
    case (state_r)
      ttcb_pkg::ST_INIT: begin
        cmd.op = ttcb_pkg::DP_CLR_STEP;
        if (stat.sweep_last) begin
          state_nxt = ttcb_pkg::ST_IDLE;
        end
      end
      ttcb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = ttcb_pkg::DP_LOAD;
          state_nxt = ttcb_pkg::ST_DECODE;
        end
      end
      ttcb_pkg::ST_DECODE: begin
        if (stat.item.action) begin
          cmd.op    = ttcb_pkg::DP_READ;
          state_nxt = ttcb_pkg::ST_RESP;
        end else if (drop_r) begin
          if (stat.item.end_of_write) begin
            drop_nxt  = 1'b0;
            phase_nxt = ttcb_pkg::ESC_IDLE;
          end
          state_nxt = ttcb_pkg::ST_RESP;
        end else begin
          eow_pend_nxt = stat.item.end_of_write;
          state_nxt    = ttcb_pkg::ST_DISPATCH;
          case (phase_r)
            ttcb_pkg::ESC_SEEN: begin
              if (b == ttcb_pkg::CH_LBRACKET) begin
                phase_nxt = ttcb_pkg::ESC_BRACKET;
              end else begin
                mismatch = 1'b1;
              end
            end
            ttcb_pkg::ESC_BRACKET: begin
              if (b == ttcb_pkg::CH_H) begin
                cmd.op    = ttcb_pkg::DP_HOME;
                phase_nxt = ttcb_pkg::ESC_IDLE;
              end else if (b == ttcb_pkg::CH_TWO) begin
                phase_nxt = ttcb_pkg::ESC_TWO;
              end else begin
                mismatch = 1'b1;
              end
            end
            ttcb_pkg::ESC_TWO: begin
              if (b == ttcb_pkg::CH_K) begin
                cmd.op    = ttcb_pkg::DP_DIV_START;
                phase_nxt = ttcb_pkg::ESC_IDLE;
                state_nxt = ttcb_pkg::ST_DIV_LINE;
              end else if (b == ttcb_pkg::CH_J) begin
                cmd.op    = ttcb_pkg::DP_SCREEN_SETUP;
                phase_nxt = ttcb_pkg::ESC_IDLE;
                state_nxt = ttcb_pkg::ST_CLEAR;
              end else begin
                mismatch = 1'b1;
              end
            end
            default: mismatch = 1'b1;
          endcase
          if (mismatch) begin
            // no match: held '[' and '2' replay as text (not ESC), then this byte
            rep_lb_nxt   = phase_r inside {ttcb_pkg::ESC_BRACKET, ttcb_pkg::ESC_TWO};
            rep_two_nxt  = (phase_r == ttcb_pkg::ESC_TWO);
            cur_pend_nxt = 1'b1;
            phase_nxt    = ttcb_pkg::ESC_IDLE;
          end
        end
      end
      ttcb_pkg::ST_DISPATCH: begin
        if (rep_lb_r) begin
          rep_lb_nxt  = 1'b0;
          start_plain = 1'b1;
          plain_chr   = ttcb_pkg::CH_LBRACKET;
        end else if (rep_two_r) begin
          rep_two_nxt = 1'b0;
          start_plain = 1'b1;
          plain_chr   = ttcb_pkg::CH_TWO;
        end else if (cur_pend_r) begin
          cur_pend_nxt = 1'b0;
          if (b == ttcb_pkg::CH_ESC) begin
            phase_nxt = ttcb_pkg::ESC_SEEN;
          end else if (b == ttcb_pkg::CH_NUL) begin
            drop_nxt = 1'b1;
          end else begin
            start_plain = 1'b1;
            plain_chr   = b;
          end
        end else if (eow_pend_r) begin
          // an open escape at the end of a write has its '[' and '2' replayed as text
          eow_pend_nxt = 1'b0;
          if (!drop_r) begin
            rep_lb_nxt  = phase_r inside {ttcb_pkg::ESC_BRACKET, ttcb_pkg::ESC_TWO};
            rep_two_nxt = (phase_r == ttcb_pkg::ESC_TWO);
          end
          phase_nxt = ttcb_pkg::ESC_IDLE;
          drop_nxt  = 1'b0;
        end else begin
          state_nxt = ttcb_pkg::ST_RESP;
        end
      end
      ttcb_pkg::ST_DIV_CR: begin
        if (!stat.div_busy) begin
          cmd.op    = ttcb_pkg::DP_CR;
          state_nxt = ttcb_pkg::ST_DISPATCH;
        end
      end
      ttcb_pkg::ST_DIV_LF: begin
        if (!stat.div_busy) begin
          cmd.op    = ttcb_pkg::DP_LF;
          state_nxt = ttcb_pkg::ST_SCROLL_CHK;
        end
      end
      ttcb_pkg::ST_DIV_LINE: begin
        if (!stat.div_busy) begin
          cmd.op    = ttcb_pkg::DP_LINE_SETUP;
          state_nxt = ttcb_pkg::ST_CLEAR;
        end
      end
      ttcb_pkg::ST_CLEAR: begin
        cmd.op = ttcb_pkg::DP_CLR_STEP;
        if (stat.sweep_last) begin
          state_nxt = ttcb_pkg::ST_SCROLL_CHK;
        end
      end
      ttcb_pkg::ST_SCROLL_CHK: begin
        if (stat.cur_ge_size) begin
          cmd.op    = ttcb_pkg::DP_SCR_SETUP;
          state_nxt = ttcb_pkg::ST_SCROLL_RUN;
        end else begin
          state_nxt = ttcb_pkg::ST_DISPATCH;
        end
      end
      ttcb_pkg::ST_SCROLL_RUN: begin
        cmd.op = ttcb_pkg::DP_SCR_STEP;
        if (stat.sweep_last) begin
          state_nxt = ttcb_pkg::ST_DISPATCH;
        end
      end
      ttcb_pkg::ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = ttcb_pkg::DP_RESP;
          out_valid_nxt = 1'b1;
          state_nxt     = ttcb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ttcb_pkg::ST_IDLE;
    endcase

    if (start_plain) begin
      case (plain_chr)
        ttcb_pkg::CH_CR: begin
          cmd.op    = ttcb_pkg::DP_DIV_START;
          state_nxt = ttcb_pkg::ST_DIV_CR;
        end
        ttcb_pkg::CH_LF: begin
          cmd.op    = ttcb_pkg::DP_DIV_START;
          state_nxt = ttcb_pkg::ST_DIV_LF;
        end
        ttcb_pkg::CH_BS: begin
          cmd.op    = ttcb_pkg::DP_BS;
          state_nxt = ttcb_pkg::ST_DISPATCH;
        end
        default: begin
          cmd.op    = ttcb_pkg::DP_PUT;
          cmd.chr   = plain_chr;
          state_nxt = ttcb_pkg::ST_SCROLL_CHK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ttcb_pkg::ST_INIT;
      phase_r     <= ttcb_pkg::ESC_IDLE;
      drop_r      <= 1'b0;
      rep_lb_r    <= 1'b0;
      rep_two_r   <= 1'b0;
      cur_pend_r  <= 1'b0;
      eow_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      drop_r      <= drop_nxt;
      rep_lb_r    <= rep_lb_nxt;
      rep_two_r   <= rep_two_nxt;
      cur_pend_r  <= cur_pend_nxt;
      eow_pend_r  <= eow_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* src/text_terminal_cell_buffer.sv */
// top level of the text terminal cell buffer: character cell store with a linear cursor
// uses ttcb_pkg, ttcb_ctrl and ttcb_dpath
//
// usage
// - input requests (in_valid/in_ready, in_req) either write one stream byte
//   (action 0) or read one cell (action 1); one result request comes back for
//   each (out_valid/out_ready, out_req) in the same order
// - cfg_we/cfg_index/cfg_data write line_width (index 0) or screen_rows
//   (index 1); write them only while no request is in flight
// - one request is worked on at a time; in_ready is high only between requests
// - CR and LF wait for the bit-serial remainder unit (one cursor bit per
//   cycle); clear-line waits for it too and then clears each cell of the
//   cursor's line; a clear-screen or a scroll walks every used cell once,
//   through the single write port of the cell store; replayed escape bytes
//   each cost their own pass
// - the result sits in an output register: the next request is taken while
//   it waits, and only the completion of that next request stalls on out_ready
// - after reset all MAX_COLS*MAX_ROWS cells of the store are cleared,
//   one cell per cycle, with in_ready held low;
//   configuration writes are taken meanwhile
// - cursor and geometry reset to 0, 80 columns and 25 rows

module text_terminal_cell_buffer #(
  parameter int MAX_COLS = 80,
  parameter int MAX_ROWS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ttcb_pkg::in_req_t                in_req,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ttcb_pkg::out_req_t               out_req,
  input  logic                             cfg_we,
  input  logic [ttcb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ttcb_pkg::CFG_W-1:0]       cfg_data
);

  localparam int CELLS   = MAX_COLS * MAX_ROWS;
  localparam int IDX_TOP = (1 << ttcb_pkg::CELL_INDEX_W) - 1;

  // command and status between the controller and the datapath
  ttcb_pkg::dp_cmd_t  cmd;
  ttcb_pkg::dp_stat_t stat;

  ttcb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // cell store, cursor, remainder unit and result register
  ttcb_dpath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_req    (in_req),
    .out_req   (out_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // one request at a time: after an acceptance the input side closes
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a request is still being worked on");

  // the remainder unit only runs inside a request
  a_div_in_request: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_busy |-> !in_ready)
    else $error("remainder unit busy while the block is open for requests");

  // a loaded result shows up on the output the cycle after
  a_resp_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == ttcb_pkg::DP_RESP |=> out_valid)
    else $error("result loaded but out_valid low");

  // the cursor reported at rest always lies inside the store
  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CELLS > IDX_TOP) || (int'(out_req.cursor_position) < CELLS))
    else $error("cursor beyond the cell store");

endmodule
